/* rtl/lpip_pkg.sv */
// Package for the lasso point-in-polygon block: sizes, coordinate types,
// opcodes and the unit-truncation helper.
// No dependencies; every other file of the block but lpip_ram imports it.
package lpip_pkg;

  localparam int MAX_POINTS = 256;
  localparam int COORD_BITS = 24;
  localparam int FRAC_BITS  = 8;
  localparam int OPC_W      = 2;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int VTX_W      = 2 * COORD_BITS;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic [CNT_W-1:0]             count_t;
  typedef logic [ADDR_W-1:0]            addr_t;

  typedef enum logic [OPC_W-1:0] {
    OP_APPEND = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_UNUSED = 2'd3
  } opcode_t;

  // One polygon edge handed to the edge unit: old vertex o, current vertex c.
  typedef struct packed {
    logic   valid;
    coord_t ox;
    coord_t oy;
    coord_t cx;
    coord_t cy;
  } edge_req_t;

  // Truncate toward zero to whole units: clear the fraction bits of the magnitude.
  function automatic diff_t trunc_units(input coord_t v);
    diff_t mag;
    mag = v[COORD_BITS-1] ? -diff_t'(v) : diff_t'(v);
    mag[FRAC_BITS-1:0] = '0;
    return v[COORD_BITS-1] ? -mag : mag;
  endfunction

endpackage

/* rtl/lpip_if.sv */
// Handshake channels of the lasso point-in-polygon block: the item input
// channel and the result channel. Depends on lpip_pkg.
interface lpip_in_if import lpip_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OPC_W-1:0]     opcode;
  logic signed [COORD_BITS-1:0] coord_x;
  logic signed [COORD_BITS-1:0] coord_y;

  modport source (output valid, output opcode, output coord_x, output coord_y, input ready);
  modport sink   (input valid, input opcode, input coord_x, input coord_y, output ready);
endinterface

interface lpip_out_if import lpip_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             inside_res;
  logic [CNT_W-1:0] vertex_count;
  logic             dropped;

  modport source (output valid, output inside_res, output vertex_count, output dropped,
                  input ready);
  modport sink   (input valid, input inside_res, input vertex_count, input dropped,
                  output ready);
endinterface

/* rtl/lpip_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module lpip_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/lpip_edge.sv */
// Edge crossing unit: takes one polygon edge a cycle, runs the even-odd ray
// test in a three-step pipeline and keeps the crossing parity. Depends on lpip_pkg.
module lpip_edge import lpip_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  coord_t    px,
  input  coord_t    py,
  input  edge_req_t req,
  output logic      parity,
  output logic      busy
);

  coord_t ox, oy, cx, cy;
  diff_t  left;
  logic   skip, direct_hit;
  diff_t  t1_nxt, t2_nxt;

  // First step registers.
  logic  s1_v_r, s1_v_nxt;
  logic  s1_hit_r, s1_mul_r, s1_dypos_r;
  diff_t t1_r, t2_r, dy_r, dx_r;

  // Second step registers.
  logic  s2_v_r, s2_v_nxt;
  logic  s2_hit_r, s2_mul_r, s2_dypos_r;
  prod_t p1_r, p2_r;

  logic  parity_r, parity_nxt;
  logic  slope_hit;

  assign ox = req.ox;
  assign oy = req.oy;
  assign cx = req.cx;
  assign cy = req.cy;

  always_comb begin
    skip = (cy == oy);
    if (cx < ox) begin
      skip = skip | (px >= ox);
      left = trunc_units(cx);
    end else begin
      skip = skip | (px >= cx);
      left = trunc_units(ox);
    end
    // The y interval is half-open: the lower end counts, the upper does not.
    if (cy < oy) begin
      skip   = skip | (py < cy) | (py >= oy);
      t1_nxt = diff_t'(px) - diff_t'(cx);
      t2_nxt = diff_t'(py) - diff_t'(cy);
    end else begin
      skip   = skip | (py < oy) | (py >= cy);
      t1_nxt = diff_t'(px) - diff_t'(ox);
      t2_nxt = diff_t'(py) - diff_t'(oy);
    end
    direct_hit = !skip && (diff_t'(px) < left);
  end

  assign s1_v_nxt = req.valid;
  assign s2_v_nxt = s1_v_r;

  // The slope test is a cross-multiplication whose direction follows the sign of dy.
  assign slope_hit = s2_dypos_r ? (p1_r < p2_r) : (p2_r < p1_r);

  always_comb begin
    parity_nxt = parity_r;
    if (start) begin
      parity_nxt = 1'b0;
    end else if (s2_v_r && (s2_hit_r || (s2_mul_r && slope_hit))) begin
      parity_nxt = !parity_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
      parity_r <= 1'b0;
    end else begin
      s1_v_r   <= s1_v_nxt;
      s2_v_r   <= s2_v_nxt;
      parity_r <= parity_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_hit_r   <= direct_hit;
    s1_mul_r   <= !skip && !direct_hit;
    s1_dypos_r <= (oy > cy);
    t1_r       <= t1_nxt;
    t2_r       <= t2_nxt;
    dy_r       <= diff_t'(oy) - diff_t'(cy);
    dx_r       <= diff_t'(ox) - diff_t'(cx);
    s2_hit_r   <= s1_hit_r;
    s2_mul_r   <= s1_mul_r;
    s2_dypos_r <= s1_dypos_r;
    p1_r       <= prod_t'(t1_r) * prod_t'(dy_r);
    p2_r       <= prod_t'(t2_r) * prod_t'(dx_r);
  end

  assign parity = parity_r;
  assign busy   = s1_v_r | s2_v_r;

endmodule

/* rtl/lasso_point_in_polygon_top.sv */
// Top level of the lasso point-in-polygon block: vertex store, bounding box,
// query sequencer and result register. Depends on lpip_pkg, lpip_if, lpip_ram, lpip_edge.
//
// The block holds a polygon of up to MAX_POINTS vertices in a RAM and answers
// one item at a time. Appends, clears, the unused opcode and queries that fall
// outside the bounding box or meet fewer than two vertices are answered straight from the idle state.
// In a full query the sequencer reads the last vertex, then streams one vertex
// a cycle out of the single read port of the vertex RAM into the edge unit,
// which tests one edge a cycle and then drains its pipeline. The result sits
// in an output register, and the next item is taken as soon as that register
// is free or is being emptied.
module lasso_point_in_polygon_top import lpip_pkg::*; (
  input logic clk,
  input logic rst_n,
  lpip_in_if.sink    in_ch,
  lpip_out_if.source out_ch
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_LAST  = 4'b0010,
    ST_WALK  = 4'b0100,
    ST_DRAIN = 4'b1000
  } state_t;

  typedef enum logic [1:0] {
    TAG_NONE = 2'd0,
    TAG_PREV = 2'd1,
    TAG_EDGE = 2'd2
  } tag_t;

  state_t state_r, state_nxt;
  tag_t   tag_r, tag_nxt;
  count_t count_r, count_nxt;
  coord_t min_x_r, min_x_nxt, max_x_r, max_x_nxt;
  coord_t min_y_r, min_y_nxt, max_y_r, max_y_nxt;
  addr_t  idx_r, idx_nxt;
  coord_t qx_r, qx_nxt, qy_r, qy_nxt;
  coord_t prev_x_r, prev_x_nxt, prev_y_r, prev_y_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_inside_r, out_inside_nxt;
  count_t out_count_r, out_count_nxt;
  logic   out_drop_r, out_drop_nxt;

  logic      accept, out_free, full;
  opcode_t   op;
  coord_t    in_x, in_y;
  count_t    cnt_m1;
  addr_t     last_idx;
  logic      outside;
  logic      ram_we, ram_re;
  addr_t     ram_raddr;
  logic [VTX_W-1:0] ram_rdata;
  coord_t    rd_x, rd_y;
  edge_req_t edge_req;
  logic      edge_start, edge_parity, edge_busy;

  assign op       = opcode_t'(in_ch.opcode);
  assign in_x     = in_ch.coord_x;
  assign in_y     = in_ch.coord_y;
  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE) && out_free;
  assign accept   = in_ch.valid && in_ch.ready;
  assign full     = (count_r >= count_t'(MAX_POINTS));
  assign cnt_m1   = count_r - count_t'(1);
  assign last_idx = cnt_m1[ADDR_W-1:0];
  assign outside  = (in_x < min_x_r) || (in_x > max_x_r) ||
                    (in_y < min_y_r) || (in_y > max_y_r);

  assign ram_we    = accept && (op == OP_APPEND) && !full;
  assign ram_re    = (state_r == ST_LAST) || (state_r == ST_WALK);
  assign ram_raddr = (state_r == ST_LAST) ? last_idx : idx_r;
  assign rd_x      = ram_rdata[VTX_W-1:COORD_BITS];
  assign rd_y      = ram_rdata[COORD_BITS-1:0];

  lpip_ram #(
    .WIDTH (VTX_W),
    .DEPTH (MAX_POINTS)
  ) u_vtx_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[ADDR_W-1:0]),
    .wdata ({in_x, in_y}),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign edge_start     = accept && (op == OP_QUERY) && !outside && (count_r >= count_t'(2));
  assign edge_req.valid = (tag_r == TAG_EDGE);
  assign edge_req.ox    = prev_x_r;
  assign edge_req.oy    = prev_y_r;
  assign edge_req.cx    = rd_x;
  assign edge_req.cy    = rd_y;

  lpip_edge u_edge (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (edge_start),
    .px     (qx_r),
    .py     (qy_r),
    .req    (edge_req),
    .parity (edge_parity),
    .busy   (edge_busy)
  );

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    min_x_nxt      = min_x_r;
    max_x_nxt      = max_x_r;
    min_y_nxt      = min_y_r;
    max_y_nxt      = max_y_r;
    idx_nxt        = idx_r;
    qx_nxt         = qx_r;
    qy_nxt         = qy_r;
    prev_x_nxt     = prev_x_r;
    prev_y_nxt     = prev_y_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_inside_nxt = out_inside_r;
    out_count_nxt  = out_count_r;
    out_drop_nxt   = out_drop_r;
    tag_nxt        = TAG_NONE;

    // Read data arrives in the cycle after its address; the tag says what it is.
    if (tag_r != TAG_NONE) begin
      prev_x_nxt = rd_x;
      prev_y_nxt = rd_y;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_valid_nxt  = 1'b1;
          out_inside_nxt = 1'b0;
          out_drop_nxt   = 1'b0;
          out_count_nxt  = count_r;
          case (op)
            OP_APPEND: begin
              if (full) begin
                out_drop_nxt = 1'b1;
              end else begin
                // The first vertex sets the box; later ones widen it.
                if (count_r == '0) begin
                  min_x_nxt = in_x;
                  max_x_nxt = in_x;
                  min_y_nxt = in_y;
                  max_y_nxt = in_y;
                end else begin
                  if (in_x < min_x_r) min_x_nxt = in_x;
                  if (in_x > max_x_r) max_x_nxt = in_x;
                  if (in_y < min_y_r) min_y_nxt = in_y;
                  if (in_y > max_y_r) max_y_nxt = in_y;
                end
                count_nxt     = count_r + count_t'(1);
                out_count_nxt = count_r + count_t'(1);
              end
            end
            OP_QUERY: begin
              if (edge_start) begin
                out_valid_nxt = 1'b0;
                qx_nxt        = in_x;
                qy_nxt        = in_y;
                state_nxt     = ST_LAST;
              end
            end
            OP_CLEAR: begin
              count_nxt     = '0;
              out_count_nxt = '0;
              min_x_nxt     = '0;
              max_x_nxt     = '0;
              min_y_nxt     = '0;
              max_y_nxt     = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_LAST: begin
        tag_nxt   = TAG_PREV;
        idx_nxt   = '0;
        state_nxt = ST_WALK;
      end
      ST_WALK: begin
        tag_nxt = TAG_EDGE;
        idx_nxt = idx_r + addr_t'(1);
        if (idx_r == last_idx) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if ((tag_r == TAG_NONE) && !edge_busy && out_free) begin
          out_valid_nxt  = 1'b1;
          out_inside_nxt = edge_parity;
          out_drop_nxt   = 1'b0;
          out_count_nxt  = count_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tag_r       <= TAG_NONE;
      count_r     <= '0;
      min_x_r     <= '0;
      max_x_r     <= '0;
      min_y_r     <= '0;
      max_y_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tag_r       <= tag_nxt;
      count_r     <= count_nxt;
      min_x_r     <= min_x_nxt;
      max_x_r     <= max_x_nxt;
      min_y_r     <= min_y_nxt;
      max_y_r     <= max_y_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    qx_r         <= qx_nxt;
    qy_r         <= qy_nxt;
    prev_x_r     <= prev_x_nxt;
    prev_y_r     <= prev_y_nxt;
    out_inside_r <= out_inside_nxt;
    out_count_r  <= out_count_nxt;
    out_drop_r   <= out_drop_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.inside_res   = out_inside_r;
  assign out_ch.vertex_count = out_count_r;
  assign out_ch.dropped      = out_drop_r;

endmodule

/* rtl/lpip_checker.sv */
// Port-level checker for the lasso point-in-polygon block, bound to the top level.
// Depends on lpip_pkg and lasso_point_in_polygon_top.
module lpip_checker import lpip_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input logic             inside_res,
  input logic [CNT_W-1:0] vertex_count,
  input logic             dropped
);

  // A result that waits must stay offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item withdrawn before it was taken");

  // A waiting result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(inside_res) && $stable(vertex_count) &&
                                $stable(dropped))
    else $error("result item changed while stalled");

  // An append is refused only when the store is full.
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && dropped |-> !inside_res && (vertex_count == CNT_W'(MAX_POINTS)))
    else $error("dropped flagged with a store that is not full");

  // Two vertices give two copies of one edge, so a hit needs at least three.
  a_inside_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && inside_res |-> (vertex_count >= CNT_W'(3)) &&
                                (vertex_count <= CNT_W'(MAX_POINTS)))
    else $error("inside reported for a degenerate polygon");

endmodule

bind lasso_point_in_polygon_top lpip_checker u_lpip_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .inside_res   (out_ch.inside_res),
  .vertex_count (out_ch.vertex_count),
  .dropped      (out_ch.dropped)
);
